@@ sv/mcd_pkg.sv @@
package mcd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FILT_W   = 24;
    localparam int SUM_W    = 25;
    localparam int SHIFT_W  = 5;
    localparam int THR_W    = 13;
    localparam int GAIN_W   = 13;
    localparam int GGAIN_W  = 15;
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [15:0]        DC_COEF    = 16'd32276;
    localparam logic [GGAIN_W-1:0] GATE_FULL  = 15'd32767;
    localparam logic [GGAIN_W-1:0] GATE_UP    = 15'd4096;
    localparam logic [GGAIN_W-1:0] GATE_DOWN  = 15'd1536;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd18;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd11;
    localparam logic [THR_W-1:0]   THR_MAX     = 13'd6000;
    localparam logic [THR_W-1:0]   THR_RESET   = 13'd0;
    localparam logic [GAIN_W-1:0]  GAIN_MIN    = 13'd64;
    localparam logic [GAIN_W-1:0]  GAIN_MAX    = 13'd4096;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 13'd1024;

    // Register indexes on the configuration port (word address).
    typedef enum logic [1:0] {
        REG_SAMPLE_SHIFT   = 2'd0,
        REG_GATE_THRESHOLD = 2'd1,
        REG_MIC_GAIN       = 2'd2
    } t_reg_idx;

    // Commands from the sequencer to the noise gate.
    typedef struct packed {
        logic clear;
        logic update;
    } t_gate_ctl;

    function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] v);
        logic [SHIFT_W-1:0] r;
        r = v;
        if (v < SHIFT_MIN) r = SHIFT_MIN;
        if (v > SHIFT_MAX) r = SHIFT_MAX;
        return r;
    endfunction

    function automatic logic [THR_W-1:0] clamp_thr(input logic [THR_W-1:0] v);
        return (v > THR_MAX) ? THR_MAX : v;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
        logic [GAIN_W-1:0] r;
        r = v;
        if (v < GAIN_MIN) r = GAIN_MIN;
        if (v > GAIN_MAX) r = GAIN_MAX;
        return r;
    endfunction

    // Saturate a 25-bit signed value to 16 bits.
    function automatic logic [SAMPLE_W-1:0] sat16(input logic [SUM_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        r = v[SAMPLE_W-1:0];
        if (!v[SUM_W-1] && (v[SUM_W-2:SAMPLE_W-1] != '0)) r = 16'h7FFF;
        if (v[SUM_W-1] && (v[SUM_W-2:SAMPLE_W-1] != '1)) r = 16'h8000;
        return r;
    endfunction

endpackage

@@ sv/mic_conditioning_decimator.sv @@
// Channel   Handshake              Payload
// input     i_valid / o_ready      i_raw_sample, i_capture_enabled, i_restart
// output    o_valid / i_ready      o_pcm_out
// config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// An enabled input beat is taken in idle, then passes through six steps of
// the sequencer, three of which use the single shared multiplier.
// A beat with capture disabled is taken in idle and only clears the state.
// Reset is synchronous and active low; it restores the register defaults and
// clears the filter, gate and decimator state.
// Only the last step can stall: it waits while an unread result still sits
// in the output register and a new one is due.
module mic_conditioning_decimator
    import mcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_raw_sample,
    input  logic                 i_capture_enabled,
    input  logic                 i_restart,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_pcm_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Sequencer steps. Each multiply step loads the shared product register,
    // which the following step consumes.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_FB,
        S_DC,
        S_GATE,
        S_MUL_GATE,
        S_MUL_GAIN,
        S_DECIM
    } t_state;

    t_state               r_state;

    // Configuration registers, held exactly as written.
    logic [SHIFT_W-1:0]   r_sample_shift;
    logic [THR_W-1:0]     r_gate_threshold;
    logic [GAIN_W-1:0]    r_mic_gain;

    // Datapath state.
    logic [SAMPLE_W-1:0]  r_x;
    logic [SAMPLE_W-1:0]  r_y;
    logic [SAMPLE_W-1:0]  r_last_input;
    logic [FILT_W-1:0]    r_last_filtered;
    logic [SAMPLE_W-1:0]  r_held;
    logic                 r_holding;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_pcm;

    logic                 w_in_accept;
    logic                 w_cfg_write;
    logic                 w_clear;
    logic [SHIFT_W-1:0]   w_shift;
    logic [THR_W-1:0]     w_thr;
    logic [GAIN_W-1:0]    w_gain;
    logic signed [31:0]   w_shifted;
    logic                 w_mul_en;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic [GGAIN_W-1:0]   w_gate_gain;
    t_gate_ctl            w_gate_ctl;
    logic [FILT_W-1:0]    w_fb;
    logic [SUM_W-1:0]     w_yy;
    logic [SAMPLE_W-1:0]  w_g;
    logic [28:0]          w_gp;
    logic [28:0]          w_gp_bias;
    logic [SAMPLE_W-1:0]  w_a;
    logic [18:0]          w_dsum;
    logic [18:0]          w_dsum_bias;
    logic [SAMPLE_W-1:0]  w_d;
    logic                 w_out_free;

    assign w_in_accept = i_valid && o_ready;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_clear     = w_in_accept && (!i_capture_enabled || i_restart);

    // Out-of-range settings are pulled into range where they are used.
    assign w_shift = clamp_shift(r_sample_shift);
    assign w_thr   = clamp_thr(r_gate_threshold);
    assign w_gain  = clamp_gain(r_mic_gain);

    // Step 1: arithmetic shift, keep the low 16 bits (wraps).
    assign w_shifted = i_raw_sample >>> w_shift;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_MUL_FB: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_last_filtered;
                w_mul_b  = {1'b0, DC_COEF};
            end
            S_MUL_GATE: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(MUL_A_W-SAMPLE_W){r_y[SAMPLE_W-1]}}, r_y};
                w_mul_b  = {{(MUL_B_W-GGAIN_W){1'b0}}, w_gate_gain};
            end
            S_MUL_GAIN: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(MUL_A_W-SAMPLE_W){w_g[SAMPLE_W-1]}}, w_g};
                w_mul_b  = {{(MUL_B_W-GAIN_W){1'b0}}, w_gain};
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    mcd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // The gate steps once per sample, after the filter output is known.
    assign w_gate_ctl.clear  = w_clear;
    assign w_gate_ctl.update = (r_state == S_GATE);

    mcd_gate u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gate_ctl),
        .i_y     (r_y),
        .i_thr   (w_thr),
        .o_gain  (w_gate_gain)
    );

    always_comb begin
        // Step 2: DC blocker. Taking bits from 15 up is a floor division by
        // 32768; the feedback is never larger in magnitude than the stored value.
        w_fb = w_prod[FILT_W+14:15];
        w_yy = {{(SUM_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x}
             - {{(SUM_W-SAMPLE_W){r_last_input[SAMPLE_W-1]}}, r_last_input}
             + {w_fb[FILT_W-1], w_fb};

        // Step 3: gated sample. A zero threshold passes the sample unchanged;
        // otherwise the Q15 product, floored, always fits in 16 bits.
        w_g = (w_thr == '0) ? r_y : w_prod[30:15];

        // Step 4: Q8 gain, divided toward zero by biasing negative products.
        w_gp      = w_prod[28:0];
        w_gp_bias = w_gp + (w_gp[28] ? 29'd255 : 29'd0);
        w_a       = sat16({{4{w_gp_bias[28]}}, w_gp_bias[28:8]});

        // Step 5: (held + 3 * current) / 4, again toward zero.
        w_dsum = {{3{r_held[SAMPLE_W-1]}}, r_held}
               + {{2{w_a[SAMPLE_W-1]}}, w_a, 1'b0}
               + {{3{w_a[SAMPLE_W-1]}}, w_a};
        w_dsum_bias = w_dsum + (w_dsum[18] ? 19'd3 : 19'd0);
        w_d = sat16({{8{w_dsum_bias[18]}}, w_dsum_bias[18:2]});
    end

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_sample_shift   <= SHIFT_RESET;
            r_gate_threshold <= THR_RESET;
            r_mic_gain       <= GAIN_RESET;
            r_last_input     <= '0;
            r_last_filtered  <= '0;
            r_held           <= '0;
            r_holding        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_cfg_write) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_SAMPLE_SHIFT:   r_sample_shift   <= pwdata[SHIFT_W-1:0];
                    REG_GATE_THRESHOLD: r_gate_threshold <= pwdata[THR_W-1:0];
                    REG_MIC_GAIN:       r_mic_gain       <= pwdata[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            // The output register empties on a taken beat unless the decimator
            // refills it in the same cycle.
            if (r_out_valid && i_ready && !(r_state == S_DECIM && r_holding)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        // Disabled capture and restart both wipe the history;
                        // only an enabled beat goes on through the chain.
                        if (w_clear) begin
                            r_last_input    <= '0;
                            r_last_filtered <= '0;
                            r_held          <= '0;
                            r_holding       <= 1'b0;
                        end
                        if (i_capture_enabled) begin
                            r_x     <= w_shifted[SAMPLE_W-1:0];
                            r_state <= S_MUL_FB;
                        end
                    end
                end
                S_MUL_FB: begin
                    r_state <= S_DC;
                end
                S_DC: begin
                    r_last_input    <= r_x;
                    r_last_filtered <= w_yy[FILT_W-1:0];
                    r_y             <= sat16(w_yy);
                    r_state         <= S_GATE;
                end
                S_GATE: begin
                    r_state <= S_MUL_GATE;
                end
                S_MUL_GATE: begin
                    r_state <= S_MUL_GAIN;
                end
                S_MUL_GAIN: begin
                    r_state <= S_DECIM;
                end
                S_DECIM: begin
                    if (!r_holding) begin
                        r_held    <= w_a;
                        r_holding <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (w_out_free) begin
                        r_pcm       <= w_d;
                        r_out_valid <= 1'b1;
                        r_held      <= w_a;
                        r_holding   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[3:2]))
            REG_SAMPLE_SHIFT:   prdata = {{(32-SHIFT_W){1'b0}}, r_sample_shift};
            REG_GATE_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, r_gate_threshold};
            REG_MIC_GAIN:       prdata = {{(32-GAIN_W){1'b0}}, r_mic_gain};
            default:            prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_pcm_out = r_pcm;

`ifndef NO_ASSERTIONS
    a_disabled_drops_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !i_capture_enabled) |=> (!r_holding && (r_state == S_IDLE)))
        else $error("disabled beat did not clear the decimator");

    a_out_only_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_holding) && !r_holding))
        else $error("result produced without a held sample");

    a_dc_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DC) |-> ($past(r_state) == S_MUL_FB))
        else $error("filter step entered without a fresh feedback product");

    a_decim_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIM && r_holding && r_out_valid && !i_ready) |=>
        (r_state == S_DECIM))
        else $error("decimator overwrote an unread result");
`endif

endmodule

@@ sv/mcd_mul.sv @@
module mcd_mul
    import mcd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    // The one multiplier of the block, shared by the filter feedback, the
    // gate and the output gain. Product is registered.
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ sv/mcd_gate.sv @@
module mcd_gate
    import mcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_gate_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_y,
    input  logic [THR_W-1:0]    i_thr,
    output logic [GGAIN_W-1:0]  o_gain
);

    logic                 r_open;
    logic [GGAIN_W-1:0]   r_gain;
    logic                 n_open;
    logic [GGAIN_W-1:0]   n_gain;
    logic [SAMPLE_W:0]    w_ysx;
    logic [SAMPLE_W:0]    w_mag;
    logic [SAMPLE_W:0]    w_thr;
    logic [SAMPLE_W:0]    w_close;
    logic [GGAIN_W:0]     w_up;

    always_comb begin
        w_ysx   = {i_y[SAMPLE_W-1], i_y};
        w_mag   = i_y[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - w_ysx) : w_ysx;
        w_thr   = (SAMPLE_W+1)'(i_thr);
        // Close level is three quarters of the threshold, zero for tiny thresholds.
        w_close = (i_thr > 13'd4) ? (w_thr - (SAMPLE_W+1)'(i_thr[THR_W-1:2]))
                                  : (SAMPLE_W+1)'(0);
        n_open  = r_open;
        if (!r_open && (w_mag >= w_thr)) begin
            n_open = 1'b1;
        end else if (r_open && (w_mag <= w_close)) begin
            n_open = 1'b0;
        end
        w_up = {1'b0, r_gain} + {1'b0, GATE_UP};
        if (n_open) begin
            n_gain = (w_up > {1'b0, GATE_FULL}) ? GATE_FULL : w_up[GGAIN_W-1:0];
        end else begin
            n_gain = (r_gain > GATE_DOWN) ? (r_gain - GATE_DOWN) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_open <= 1'b0;
            r_gain <= GATE_FULL;
        end else if (i_ctl.update) begin
            if (i_thr == '0) begin
                r_open <= 1'b1;
                r_gain <= GATE_FULL;
            end else begin
                r_open <= n_open;
                r_gain <= n_gain;
            end
        end
    end

    assign o_gain = r_gain;

endmodule

@@ verif/mcd_pcm_checker.sv @@
`timescale 1ns / 100ps

module mcd_pcm_checker
    import mcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [31:0]        i_raw_sample,
    input  logic               i_capture_enabled,
    input  logic               i_restart,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_pcm_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Register copies, held unclamped as written.
    int shift_cfg;
    int thr_cfg;
    int gain_cfg;

    // Chain state.
    logic signed [15:0] in_mem;
    logic signed [23:0] filt_mem;
    logic               gate_on;
    int                 gate_gain_q15;
    logic signed [15:0] held_pcm;
    logic               holding;

    logic signed [15:0] pcm_expected [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] pcm check: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic void clear_chain();
        in_mem        = '0;
        filt_mem      = '0;
        gate_on       = 1'b0;
        gate_gain_q15 = int'(GATE_FULL);
        held_pcm      = '0;
        holding       = 1'b0;
    endfunction

    // Runs one beat through the chain; returns 1 when a decimated sample is due.
    function automatic bit condition_sample(input logic [31:0] raw, input logic en,
                                            input logic rst, output logic signed [15:0] pcm);
        int                 sh;
        int                 thr;
        int                 gain;
        int                 close_lvl;
        int                 target;
        int                 step;
        int                 ramp_gain;
        logic signed [31:0] shifted;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] g;
        logic signed [15:0] a;
        longint             fb;
        longint             yy;
        longint             mag;
        pcm = '0;
        if (!en) begin
            clear_chain();
            return 1'b0;
        end
        if (rst) begin
            clear_chain();
        end
        sh   = shift_cfg < 8 ? 8 : (shift_cfg > 18 ? 18 : shift_cfg);
        thr  = thr_cfg > 6000 ? 6000 : thr_cfg;
        gain = gain_cfg < 64 ? 64 : (gain_cfg > 4096 ? 4096 : gain_cfg);

        shifted = $signed(raw) >>> sh;
        x       = shifted[15:0];

        // DC blocker; the feedback product rounds towards minus infinity.
        fb       = (longint'(filt_mem) * longint'(DC_COEF)) >>> 15;
        yy       = longint'(x) - longint'(in_mem) + fb;
        in_mem   = x;
        filt_mem = yy[23:0];
        y        = clip16(yy);

        if (thr == 0) begin
            gate_on       = 1'b1;
            gate_gain_q15 = int'(GATE_FULL);
            g             = y;
        end else begin
            mag       = (y < 0) ? -longint'(y) : longint'(y);
            close_lvl = (thr > 4) ? thr - thr / 4 : 0;
            if (!gate_on && mag >= thr) begin
                gate_on = 1'b1;
            end else if (gate_on && mag <= close_lvl) begin
                gate_on = 1'b0;
            end
            target = gate_on ? int'(GATE_FULL) : 0;
            step   = gate_on ? int'(GATE_UP) : int'(GATE_DOWN);
            if (gate_gain_q15 < target) begin
                ramp_gain     = gate_gain_q15 + step;
                gate_gain_q15 = (ramp_gain > target) ? target : ramp_gain;
            end else if (gate_gain_q15 > target) begin
                ramp_gain     = (gate_gain_q15 > step) ? gate_gain_q15 - step : 0;
                gate_gain_q15 = (ramp_gain < target) ? target : ramp_gain;
            end
            g = clip16((longint'(y) * longint'(gate_gain_q15)) >>> 15);
        end

        // Q8 gain divides towards zero.
        a = clip16((longint'(g) * longint'(gain)) / 256);

        if (!holding) begin
            held_pcm = a;
            holding  = 1'b1;
            return 1'b0;
        end
        pcm      = clip16((longint'(held_pcm) + 3 * longint'(a)) / 4);
        held_pcm = a;
        holding  = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [15:0] pcm_pred;
        logic signed [15:0] pcm_want;
        if (!i_rst_n) begin
            shift_cfg = int'(SHIFT_RESET);
            thr_cfg   = int'(THR_RESET);
            gain_cfg  = int'(GAIN_RESET);
            clear_chain();
            pcm_expected.delete();
        end else begin
            // Results leaving now stem from earlier beats, so retire them first.
            if (i_out_valid && i_out_ready) begin
                if (pcm_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected pcm_out %0d", i_pcm_out));
                end else begin
                    pcm_want = pcm_expected.pop_front();
                    if (i_pcm_out !== pcm_want) begin
                        report_mismatch($sformatf("pcm_out got %0d, expected %0d",
                                                  i_pcm_out, pcm_want));
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_SAMPLE_SHIFT: begin
                        shift_cfg = int'(i_pwdata[SHIFT_W-1:0]);
                    end
                    REG_GATE_THRESHOLD: begin
                        thr_cfg = int'(i_pwdata[THR_W-1:0]);
                    end
                    REG_MIC_GAIN: begin
                        gain_cfg = int'(i_pwdata[GAIN_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (condition_sample(i_raw_sample, i_capture_enabled, i_restart, pcm_pred)) begin
                    pcm_expected.push_back(pcm_pred);
                end
            end
        end
        o_pending = pcm_expected.size();
    end

endmodule

@@ verif/tb_mic_conditioning_decimator.sv @@
`timescale 1ns / 100ps

module tb_mic_conditioning_decimator;
    import mcd_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 6;
    // This comfortably covers an enabled beat that is still in flight inside the
    // block but will never produce a result.
    localparam int DRAIN_CYCLES = 16;
    // The slowest correct run is roughly 1800 beats, each with its idle gap, busy
    // steps and a possible output stall; this limit leaves ample headroom.
    localparam int CYCLE_LIMIT  = 400000;

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_valid           = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_raw_sample      = '0;
    logic               i_capture_enabled = 1'b0;
    logic               i_restart         = 1'b0;
    logic               o_valid;
    logic               i_ready           = 1'b0;
    logic signed [15:0] o_pcm_out;
    logic               psel              = 1'b0;
    logic               penable           = 1'b0;
    logic               pwrite            = 1'b0;
    logic [3:0]         paddr             = '0;
    logic [31:0]        pwdata            = '0;
    logic [31:0]        prdata;
    logic               pready;

    int pcm_fail_count;
    int pcm_pending;
    int cycle_count  = 0;

    // Upper bounds for the idle cycles each side draws before every beat.
    int tx_gap_max   = 15;
    int rx_gap_max   = 15;

    // Register values as last written, kept only to shape the stimulus.
    int cur_shift    = 11;
    int cur_thr      = 0;

    // Burst shaping: the level is held for a run of beats so that the gate sees
    // sustained loud, quiet and borderline passages rather than white noise.
    int burst_left   = 0;
    int burst_amp    = 0;

    mic_conditioning_decimator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_sample      (i_raw_sample),
        .i_capture_enabled (i_capture_enabled),
        .i_restart         (i_restart),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pcm_out         (o_pcm_out),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // The checker sits beside the block, watches both channels and the register
    // port, and hands back its failure count and the number of results owed.
    mcd_pcm_checker u_pcm_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_raw_sample      (i_raw_sample),
        .i_capture_enabled (i_capture_enabled),
        .i_restart         (i_restart),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_pcm_out         (o_pcm_out),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_fail_count      (pcm_fail_count),
        .o_pending         (pcm_pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output side. A beat taken at a rising edge is noted here, and the falling
    // edge process then draws how long the receiver holds ready low before it
    // will take the next beat. With rx_gap_max at zero, ready simply stays high.
    logic rx_beat = 1'b0;

    always @(posedge i_clk) begin
        rx_beat <= o_valid && i_ready;
    end

    always @(negedge i_clk) begin : rx_side
        int rx_wait;
        if (rx_beat) begin
            rx_wait = $urandom_range(0, rx_gap_max);
        end
        if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // One APB write: a setup cycle, then the access cycle, held until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Presents one input beat after a random idle gap and returns once it has
    // been taken. Valid is left high afterwards: if the next beat follows with
    // no gap it stays high, so valid is never dropped and raised in one step.
    task automatic send_item(input logic [31:0] raw, input logic en, input logic rst);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_raw_sample      <= raw;
        i_capture_enabled <= en;
        i_restart         <= rst;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    // Holds the sender off until every owed result has arrived, then lets the
    // block finish any beat that is still working towards no result at all.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pcm_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Picks the next raw word. A share are full-range words and rail values;
    // the rest are scaled so that, after the shift, they sit quiet, around the
    // gate threshold, or well above it.
    function automatic logic [31:0] next_raw();
        int pick;
        int sh;
        int lim;
        int amp;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            return $urandom();
        end
        if (pick < 20) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
                0:       burst_amp = cur_thr / 2;
                1:       burst_amp = cur_thr + cur_thr / 4;
                default: burst_amp = $urandom_range(cur_thr, 32767);
            endcase
        end
        burst_left--;
        sh  = cur_shift < 8 ? 8 : (cur_shift > 18 ? 18 : cur_shift);
        // Keep the scaled value inside 32 bits so the level survives the shift.
        lim = (1 << (31 - sh)) - 1;
        if (lim > 32767) begin
            lim = 32767;
        end
        amp = (burst_amp > lim) ? lim : burst_amp;
        v   = $urandom_range(0, amp);
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return (v << sh) | ($urandom() & ((1 << sh) - 1));
    endfunction

    // One setting of the three registers, followed by a run of random beats.
    // Capture is dropped now and then, and restarts are rare, so that most beats
    // build up filter and gate history before anything clears it.
    task automatic run_phase(input int shift, input int thr, input int gain,
                             input int tx_max, input int rx_max, input int items);
        settle();
        write_reg(REG_SAMPLE_SHIFT, shift);
        write_reg(REG_GATE_THRESHOLD, thr);
        write_reg(REG_MIC_GAIN, gain);
        cur_shift  = shift;
        cur_thr    = thr;
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        burst_left = 0;
        repeat (items) begin
            send_item(next_raw(), $urandom_range(0, 49) != 0, $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        // Reset is held at the start and never asserted again.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset settings: shift 11, gate off, gain x4.
        // Rail inputs wrap in the 16-bit conversion and stay clear of saturation.
        send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_item(32'h8000_0000, 1'b1, 1'b0);
        send_item(32'h0000_0000, 1'b1, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        // Capture off clears everything, and the restart flag is ignored then.
        send_item(32'h8000_0000, 1'b0, 1'b1);
        send_item(32'h1234_5678, 1'b1, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
        // This restart falls between pairs, with no held half to drop.
        send_item(32'h8000_0000, 1'b1, 1'b1);
        send_item(32'h4000_0000, 1'b1, 1'b0);

        // Smallest shift makes the first conversion wrap; a threshold below
        // five puts the closing level at zero; gain at its top end.
        settle();
        write_reg(REG_SAMPLE_SHIFT, 32'd8);
        write_reg(REG_GATE_THRESHOLD, 32'd3);
        write_reg(REG_MIC_GAIN, 32'd4096);
        send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_item(32'h0040_0000, 1'b1, 1'b0);
        send_item(32'h0000_0000, 1'b1, 1'b0);
        send_item(32'h0000_0000, 1'b1, 1'b1);

        // Gate hysteresis at a threshold of 1000 (closing at 750): open on a
        // step, hold on the decaying tail, close on the swing back, reopen.
        settle();
        write_reg(REG_GATE_THRESHOLD, 32'd1000);
        cur_thr = 1000;
        send_item(32'd0, 1'b1, 1'b1);
        send_item(32'd2000 << 8, 1'b1, 1'b0);
        send_item(32'd2000 << 8, 1'b1, 1'b0);
        send_item(32'd0, 1'b1, 1'b0);
        send_item(32'd0, 1'b1, 1'b0);
        send_item(32'd1200 << 8, 1'b1, 1'b0);
        send_item(32'd800 << 8, 1'b1, 1'b0);

        // Random phases: range ends, values beyond the ranges that the block
        // must clamp, the small-threshold boundary, and mixed idling patterns,
        // including stretches where neither side idles at all.
        run_phase(8, 0, 64, 15, 15, 150);
        run_phase(18, 6000, 4096, 15, 15, 150);
        run_phase(31, 8191, 8191, 0, 0, 120);
        run_phase(0, 1, 0, 15, 0, 150);
        run_phase(11, 4, 256, 0, 15, 150);
        run_phase(12, 5, 300, 15, 15, 150);
        repeat (6) begin
            run_phase($urandom_range(8, 18), $urandom_range(0, 6000),
                      $urandom_range(64, 4096), 15, 15, 150);
        end

        // Wait for every owed result, then a little longer for strays.
        settle();
        if (pcm_fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
